// ----- rtl/bchd_pkg.sv -----
`default_nettype none

package bchd_pkg;

  localparam int unsigned NumChannels = 8;

  localparam int unsigned ButtonW  = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ChannelW = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // channel, buttons, now_ms packed and padded to whole bytes
  localparam int unsigned InDataW  = ((ChannelW + ButtonW + TimeW + 7) / 8) * 8;
  // fired, fired_channel, holding
  localparam int unsigned OutDataW = ((1 + ChannelW + 1 + 7) / 8) * 8;

  localparam logic [ButtonW-1:0] AllOnes = {ButtonW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgComboButtons = 2'd0,
    CfgHoldTarget   = 2'd1,
    CfgChannelMask  = 2'd2
  } cfg_index_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdClear  = 1'b1
  } command_e;

endpackage

`default_nettype wire

// ----- rtl/button_combo_hold_detector.sv -----
`default_nettype none

// Watches up to eight controller channels for one exact button combination held longer
// than a programmed time. Each request is a sample (channel, 32-bit button word,
// wrapping millisecond time) or, with tuser high, a clear of all channel history, and
// each request gives exactly one result: fired, the request's channel and whether that
// channel is timing a hold. A hold starts only when the buttons change to exactly the
// combo (not by releasing buttons from a superset), and it fires once when the wrapping
// elapsed time exceeds the target. The block takes one request per cycle unless the
// result stream stalls; a request waits in the input register, where its channel state
// is read and updated and its result written to the output register once that register
// can advance, and the result is offered from there. Configuration writes are
// taken at any time but must only be made while no request is in flight.
module button_combo_hold_detector #(
  parameter int unsigned CHANNELS = bchd_pkg::NumChannels
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bchd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bchd_pkg::CfgDataW-1:0] cfg_data_i,
  // request stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [2:0] channel, [34:3] buttons, [66:35] now_ms, rest zero
  input  wire logic [bchd_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] command
  input  wire logic                          s_axis_tuser_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] fired, [3:1] fired_channel, [4] holding, rest zero
  output logic [bchd_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned BtnW = bchd_pkg::ButtonW;
  localparam int unsigned TmW  = bchd_pkg::TimeW;
  localparam int unsigned ChW  = bchd_pkg::ChannelW;

  // configuration registers
  logic [BtnW-1:0]              combo_q;
  logic [TmW-1:0]               target_q;
  logic [bchd_pkg::MaskW-1:0]   mask_q;

  // per-channel history
  logic [BtnW-1:0] prev_q  [CHANNELS];
  logic [TmW-1:0]  start_q [CHANNELS];
  logic [CHANNELS-1:0] hold_q;
  logic [CHANNELS-1:0] fired_q;

  // input register
  logic                 in_valid_q;
  bchd_pkg::command_e   in_cmd_q;
  logic [ChW-1:0]       in_ch_q;
  logic [BtnW-1:0]      in_btn_q;
  logic [TmW-1:0]       in_now_q;

  // result register
  logic                 out_valid_q;
  logic                 out_fired_q;
  logic [ChW-1:0]       out_ch_q;
  logic                 out_hold_q;

  logic advance;
  logic process;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combo_q  <= '0;
      target_q <= '0;
      mask_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (bchd_pkg::cfg_index_e'(cfg_index_i))
        bchd_pkg::CfgComboButtons: combo_q  <= cfg_data_i[BtnW-1:0];
        bchd_pkg::CfgHoldTarget:   target_q <= cfg_data_i[TmW-1:0];
        bchd_pkg::CfgChannelMask:  mask_q   <= cfg_data_i[bchd_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q <= bchd_pkg::command_e'(s_axis_tuser_i);
      in_ch_q  <= s_axis_tdata_i[ChW-1:0];
      in_btn_q <= s_axis_tdata_i[ChW +: BtnW];
      in_now_q <= s_axis_tdata_i[ChW+BtnW +: TmW];
    end
  end

  // read-modify-write of the addressed channel
  logic [IdxW-1:0] idx;
  logic            in_range;
  logic            watched;
  logic [BtnW-1:0] prev;
  logic            prev_has;
  logic            changed;
  logic            match;
  logic            cur_hold;
  logic            keep;
  logic [TmW-1:0]  start_eff;
  logic [TmW-1:0]  elapsed;
  logic            fire;
  logic            hold_next;
  logic            fired_next;
  logic            upd;
  logic            start_wr;
  logic            res_hold;

  always_comb begin
    idx       = IdxW'(in_ch_q);
    in_range  = 32'(in_ch_q) < CHANNELS;
    watched   = in_range && mask_q[in_ch_q];
    prev      = prev_q[idx];
    cur_hold  = hold_q[idx];
    prev_has  = (prev & combo_q) == combo_q;
    changed   = prev != in_btn_q;
    match     = in_btn_q == combo_q;
    keep      = !(changed && prev_has) && (cur_hold || changed) && match;
    // a fresh hold times from this sample
    start_eff = cur_hold ? start_q[idx] : in_now_q;
    elapsed   = in_now_q - start_eff;
    fire      = keep && (elapsed > target_q) && !fired_q[idx];
    hold_next = keep;
    fired_next = keep && (fired_q[idx] || fire);
    upd       = process && (in_cmd_q == bchd_pkg::CmdSample) && watched;
    start_wr  = upd && keep && !cur_hold;
    if (!in_range) begin
      res_hold = 1'b0;
    end else if (watched) begin
      res_hold = hold_next;
    end else begin
      res_hold = cur_hold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prev_q[c] <= bchd_pkg::AllOnes;
      end
      hold_q  <= '0;
      fired_q <= '0;
    end else if (process && (in_cmd_q == bchd_pkg::CmdClear)) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prev_q[c] <= bchd_pkg::AllOnes;
      end
      hold_q  <= '0;
      fired_q <= '0;
    end else if (upd) begin
      prev_q[idx]  <= in_btn_q;
      hold_q[idx]  <= hold_next;
      fired_q[idx] <= fired_next;
    end
  end

  // only read while the channel's hold is active, so it needs no reset
  always_ff @(posedge clk_i) begin
    if (start_wr) begin
      start_q[idx] <= in_now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_ch_q <= in_ch_q;
      if (in_cmd_q == bchd_pkg::CmdClear) begin
        out_fired_q <= 1'b0;
        out_hold_q  <= 1'b0;
      end else begin
        out_fired_q <= watched && fire;
        out_hold_q  <= res_hold;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(bchd_pkg::OutDataW - ChW - 2){1'b0}},
                            out_hold_q, out_ch_q, out_fired_q};

  a_fired_implies_holding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fired_q |-> out_hold_q)
    else $error("result fired without an active hold");

  a_fired_only_while_holding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fired_q & ~hold_q) == '0)
    else $error("fired flag set on a channel with no active hold");

  a_clear_drops_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && (in_cmd_q == bchd_pkg::CmdClear) |=> (hold_q == '0) && (fired_q == '0))
    else $error("clear request left channel history behind");

  a_stalled_request_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_ch_q) && $stable(in_btn_q))
    else $error("pending request lost in the input register");

endmodule

`default_nettype wire

// ----- tb/sv/tb_button_combo_hold_detector.sv -----
`timescale 1ns / 1ps

module tb_button_combo_hold_detector;
  import bchd_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  // same bit order as the result tdata: fired at bit 0
  typedef struct packed {
    logic                holding;
    logic [ChannelW-1:0] channel;
    logic                fired;
  } hold_result_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_index_e          cfg_index = CfgComboButtons;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  command_e            s_tuser   = CmdSample;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  // predictor copy of the registers and the per-channel history
  logic [ButtonW-1:0] combo_word;
  logic [TimeW-1:0]   target_ms;
  logic [MaskW-1:0]   watch_mask;
  logic [ButtonW-1:0] last_buttons [NumChannels];
  logic [TimeW-1:0]   hold_start   [NumChannels];
  logic               hold_on      [NumChannels];
  logic               fired_once   [NumChannels];
  logic [TimeW-1:0]   clock_ms     [NumChannels];

  hold_result_t pending_results [$];

  int errors       = 0;
  int requests     = 0;
  int clears       = 0;
  int results_seen = 0;
  int triggers     = 0;
  int sender_pct   = 0;
  int recv_pct     = 0;
  int stall_left   = 0;
  int cycle_count  = 0;
  bit calm         = 1'b0;

  button_combo_hold_detector i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_history();
    for (int c = 0; c < NumChannels; c++) begin
      last_buttons[c] = AllOnes;
      hold_start[c]   = '0;
      hold_on[c]      = 1'b0;
      fired_once[c]   = 1'b0;
    end
  endfunction

  function automatic void predict_hold_step(input command_e cmd,
                                            input logic [ChannelW-1:0] ch,
                                            input logic [ButtonW-1:0] btn,
                                            input logic [TimeW-1:0] now);
    hold_result_t       res;
    logic [ButtonW-1:0] prev;
    logic [TimeW-1:0]   elapsed;
    logic               prev_has, changed, match;
    res         = '0;
    res.channel = ch;
    if (cmd == CmdClear) begin
      clear_history();
    end else begin
      if (watch_mask[ch]) begin
        prev     = last_buttons[ch];
        prev_has = (prev & combo_word) == combo_word;
        changed  = prev != btn;
        match    = btn == combo_word;
        last_buttons[ch] = btn;
        // releasing from a superset never starts a hold
        if (!(changed && prev_has) && (hold_on[ch] || changed) && match) begin
          if (!hold_on[ch]) begin
            hold_on[ch]    = 1'b1;
            hold_start[ch] = now;
          end
          elapsed = now - hold_start[ch];
          if (elapsed > target_ms && !fired_once[ch]) begin
            res.fired      = 1'b1;
            fired_once[ch] = 1'b1;
            triggers++;
          end
        end else begin
          fired_once[ch] = 1'b0;
          hold_on[ch]    = 1'b0;
          hold_start[ch] = '0;
        end
      end
      res.holding = hold_on[ch];
    end
    pending_results.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch in %s at result %0d: expected %0h, got %0h",
             what, results_seen, want, got);
    errors++;
  endtask

  task automatic send_request(input command_e cmd, input logic [ChannelW-1:0] ch,
                              input logic [ButtonW-1:0] btn, input logic [TimeW-1:0] now);
    logic [InDataW-1:0] word;
    word = '0;
    word[ChannelW-1:0]               = ch;
    word[ChannelW +: ButtonW]        = btn;
    word[ChannelW + ButtonW +: TimeW] = now;
    if (!calm && $urandom_range(0, 99) < sender_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    requests++;
    if (cmd == CmdClear) clears++;
    predict_hold_step(cmd, ch, btn, now);
  endtask

  task automatic send_sample(input logic [ChannelW-1:0] ch, input logic [ButtonW-1:0] btn,
                             input logic [TimeW-1:0] now);
    send_request(CmdSample, ch, btn, now);
  endtask

  // stop requests and wait until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgComboButtons: combo_word = value;
      CfgHoldTarget:   target_ms  = value;
      CfgChannelMask:  watch_mask = value[MaskW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [ButtonW-1:0] combo, input logic [TimeW-1:0] target,
                           input logic [MaskW-1:0] mask);
    settle();
    write_register(CfgComboButtons, combo);
    write_register(CfgHoldTarget, target);
    write_register(CfgChannelMask, CfgDataW'(mask));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // nothing watched after reset
    send_sample(3'd5, '0, '0);
    send_request(CmdClear, 3'd7, AllOnes, 32'hFFFF_FFFF);
    configure('0, '0, '0);
    send_sample(3'd0, AllOnes, 32'd1);
  endtask

  task automatic test_hold_and_fire();
    configure(32'h0000_0300, 32'd100, 8'hFF);
    send_sample(3'd0, 32'h0, 32'd1000);
    send_sample(3'd0, 32'h0000_0300, 32'd1010);
    send_sample(3'd0, 32'h0000_0300, 32'd1110);
    send_sample(3'd0, 32'h0000_0300, 32'd1111);
    send_sample(3'd0, 32'h0000_0300, 32'd1500);
    send_sample(3'd0, 32'h0000_0100, 32'd1510);
  endtask

  task automatic test_superset_release();
    send_sample(3'd3, 32'h8000_0B00, 32'd0);
    send_sample(3'd3, 32'h0000_0300, 32'd5);
  endtask

  task automatic test_time_wrap();
    configure(32'h0000_0300, 32'h10, 8'hFF);
    send_sample(3'd6, 32'h0, 32'hFFFF_FFF8);
    send_sample(3'd6, 32'h0000_0300, 32'hFFFF_FFFA);
    send_sample(3'd6, 32'h0000_0300, 32'h0000_000B);
  endtask

  task automatic test_target_extremes();
    // zero target: fires on the first sample after the start one that advances time
    configure(AllOnes, '0, 8'hFF);
    send_sample(3'd1, '0, 32'd7);
    send_sample(3'd1, AllOnes, 32'd7);
    send_sample(3'd1, AllOnes, 32'd8);
    // largest target never fires
    configure(32'h5A5A_0001, '1, 8'h04);
    send_sample(3'd2, '0, 32'd0);
    send_sample(3'd2, 32'h5A5A_0001, 32'd0);
    send_sample(3'd2, 32'h5A5A_0001, 32'hFFFF_FFFF);
  endtask

  task automatic test_unwatched_and_clear();
    configure(32'h0000_0300, '1, 8'hFF);
    send_sample(3'd4, 32'h0, 32'd100);
    send_sample(3'd4, 32'h0000_0300, 32'd200);
    // hold state must survive while the channel is unwatched
    configure(32'h0000_0300, '1, 8'hEF);
    send_sample(3'd4, 32'hDEAD_BEEF, 32'd300);
    send_request(CmdClear, 3'd2, 32'h1234_5678, 32'h9ABC_DEF0);
    configure(32'h0000_0300, '1, 8'hFF);
    // history is all ones after clear, so this is a release from a superset
    send_sample(3'd4, 32'h0000_0300, 32'd400);
  endtask

  task automatic test_random_phase(input int phase, input int count);
    logic [ButtonW-1:0]  combo;
    logic [TimeW-1:0]    target;
    logic [MaskW-1:0]    mask;
    logic [ChannelW-1:0] ch;
    logic [ButtonW-1:0]  btn;
    logic [TimeW-1:0]    now;
    int                  pick;
    int                  step_max;
    case (phase)
      0:       combo = AllOnes;
      1:       combo = '0;
      2, 5:    combo = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
      default: combo = $urandom();
    endcase
    case (phase)
      3:       target = '0;
      4:       target = '1;
      default: target = $urandom_range(0, 60);
    endcase
    case (phase % 3)
      0:       mask = 8'hFF;
      1:       mask = MaskW'($urandom_range(1, 255));
      default: mask = (phase < 3) ? 8'h01 : 8'h80;
    endcase
    configure(combo, target, mask);
    sender_pct = (phase % 3) * 12;
    recv_pct   = ((phase + 1) % 3) * 10;
    calm       = (phase == 5);
    step_max   = (target > 60) ? 5000 : 20;
    for (int c = 0; c < NumChannels; c++) begin
      clock_ms[c] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                : $urandom();
    end
    repeat (count) begin
      ch = ChannelW'($urandom_range(0, NumChannels - 1));
      if ($urandom_range(0, 4) != 0) begin
        while (!mask[ch]) ch = ChannelW'($urandom_range(0, NumChannels - 1));
      end
      now = ($urandom_range(0, 39) == 0) ? $urandom()
                                         : clock_ms[ch] + $urandom_range(0, step_max);
      clock_ms[ch] = now;
      pick = $urandom_range(0, 99);
      if (pick < 55) btn = combo;
      else if (pick < 68) btn = combo ^ (32'd1 << $urandom_range(0, 31));
      else if (pick < 78) btn = combo | $urandom();
      else if (pick < 90) btn = $urandom();
      else btn = $urandom_range(0, 1) ? AllOnes : '0;
      if (pick >= 95) send_request(CmdClear, ch, $urandom(), $urandom());
      else send_sample(ch, btn, now);
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < recv_pct) begin
      stall_left <= $urandom_range(0, 17);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hold_result_t got;
    hold_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = hold_result_t'(m_tdata[4:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, 32'(m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.fired != want.fired)
          report_mismatch("fired", 32'(want.fired), 32'(got.fired));
        if (got.channel != want.channel)
          report_mismatch("fired_channel", 32'(want.channel), 32'(got.channel));
        if (got.holding != want.holding)
          report_mismatch("holding", 32'(want.holding), 32'(got.holding));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("[button_combo_hold_detector] ERROR");
      $finish;
    end
  end

  initial begin
    clear_history();
    combo_word = '0;
    target_ms  = '0;
    watch_mask = '0;
    sender_pct = 10;
    recv_pct   = 10;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_hold_and_fire();
    test_superset_release();
    test_time_wrap();
    test_target_extremes();
    test_unwatched_and_clear();
    for (int p = 0; p < 6; p++) test_random_phase(p, 112);
    settle();
    repeat (8) @(posedge clk);
    $display("ran %0d requests (%0d clears), checked %0d results, %0d hold triggers",
             requests, clears, results_seen, triggers);
    $display("directed holds, wrap, superset release, target extremes, then 6 random setups");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[button_combo_hold_detector] OK");
    end else begin
      $display("[button_combo_hold_detector] ERROR");
    end
    $finish;
  end

endmodule
